### rtl/weighted_spectrum_resampler_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the weighted spectrum resampler.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_SPECTRUM_RESAMPLER_MACROS_SVH
`define WEIGHTED_SPECTRUM_RESAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsr assertion failed");

`endif

### rtl/wsr_pkg.sv
// ---------------------------------------------------------------------------
// wsr_pkg
// Shared types and constants of the weighted spectrum resampler.
// ---------------------------------------------------------------------------
package wsr_pkg;

    // Request operation codes.
    typedef enum logic [1:0] {
        FUNC_GRID   = 2'd0,
        FUNC_FLUX   = 2'd1,
        FUNC_WEIGHT = 2'd2,
        FUNC_QUERY  = 2'd3
    } t_func;

    // Configuration register indexes.
    localparam logic CFG_MODELS = 1'b0;
    localparam logic CFG_POINTS = 1'b1;

    localparam int MODEL_IDX_W = 6;
    localparam int POINT_IDX_W = 12;
    localparam int WAVE_W      = 16;
    localparam int FLUX_W      = 16;
    localparam int WEIGHT_W    = 16;
    localparam int RESULT_W    = 32;
    localparam int MODELS_W    = 7;
    localparam int POINTS_W    = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;

    localparam logic [MODELS_W-1:0] MODELS_RESET = 7'd50;
    localparam logic [POINTS_W-1:0] POINTS_RESET = 13'd3501;

    // Multiplier operand width and accumulator width.
    localparam int MUL_W = 18;
    localparam int ACC_W = 48;

    // Quotient bits of the interpolation fraction.
    localparam int DIV_STEPS = 16;

endpackage

### rtl/wsr_if.sv
// ---------------------------------------------------------------------------
// wsr_req_if / wsr_rsp_if
// Valid/ready channels for requests and results of the resampler.
// ---------------------------------------------------------------------------
interface wsr_req_if
    import wsr_pkg::*;
();
    logic                          valid;
    logic                          ready;
    t_func                         func;
    logic [MODEL_IDX_W-1:0]        model_index;
    logic [POINT_IDX_W-1:0]        point_index;
    logic [WAVE_W-1:0]             wavelength;
    logic [FLUX_W-1:0]             flux_sample;
    logic signed [WEIGHT_W-1:0]    weight;

    modport source (output valid, func, model_index, point_index, wavelength,
                    flux_sample, weight, input ready);
    modport sink   (input valid, func, model_index, point_index, wavelength,
                    flux_sample, weight, output ready);
endinterface

interface wsr_rsp_if
    import wsr_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [RESULT_W-1:0]    synthesized_flux;
    logic                          saturated;

    modport source (output valid, synthesized_flux, saturated, input ready);
    modport sink   (input valid, synthesized_flux, saturated, output ready);
endinterface

### rtl/wsr_div.sv
// ---------------------------------------------------------------------------
// wsr_div
// Restoring serial divider, one quotient bit per cycle. The numerator must
// be below the denominator, so the quotient is a pure 16-bit fraction.
// ---------------------------------------------------------------------------
module wsr_div
    import wsr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WAVE_W-1:0]    i_numer,
    input  logic [WAVE_W-1:0]    i_denom,
    output logic                 o_done,
    output logic [DIV_STEPS-1:0] o_quot
);
    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [WAVE_W-1:0]    r_rem;
    logic [WAVE_W-1:0]    r_den;
    logic [DIV_STEPS-1:0] r_q;
    logic [WAVE_W:0]      shifted;
    logic                 fits;

    // Trial subtraction of the doubled remainder.
    assign shifted = {r_rem, 1'b0};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_STEPS);
                r_rem  <= i_numer;
                r_den  <= i_denom;
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= fits ? WAVE_W'(shifted - {1'b0, r_den}) : WAVE_W'(shifted);
                r_q   <= {r_q[DIV_STEPS-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

### rtl/wsr_mul.sv
// ---------------------------------------------------------------------------
// wsr_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module wsr_mul
    import wsr_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_W-1:0]   i_a,
    input  logic signed [MUL_W-1:0]   i_b,
    output logic signed [2*MUL_W-1:0] o_prod
);
    logic signed [2*MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

### rtl/wsr_mem.sv
// ---------------------------------------------------------------------------
// wsr_mem
// Grid, flux and weight memories: one write and one registered read each.
// ---------------------------------------------------------------------------
module wsr_mem
    import wsr_pkg::*;
#(
    parameter int AW = 12,
    parameter int MW = 6,
    parameter int MAX_MODELS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_grid_we,
    input  logic [AW-1:0]              i_grid_waddr,
    input  logic [AW-1:0]              i_grid_raddr,
    input  logic [WAVE_W-1:0]          i_grid_wdata,
    output logic [WAVE_W-1:0]          o_grid_rdata,
    input  logic                       i_flux_we,
    input  logic [MW+AW-1:0]           i_flux_waddr,
    input  logic [MW+AW-1:0]           i_flux_raddr,
    input  logic [FLUX_W-1:0]          i_flux_wdata,
    output logic [FLUX_W-1:0]          o_flux_rdata,
    input  logic                       i_wt_we,
    input  logic [MW-1:0]              i_wt_waddr,
    input  logic [MW-1:0]              i_wt_raddr,
    input  logic [WEIGHT_W-1:0]        i_wt_wdata,
    output logic [WEIGHT_W-1:0]        o_wt_rdata
);
    logic [WAVE_W-1:0]   grid_mem [0:(2**AW)-1];
    logic [FLUX_W-1:0]   flux_mem [0:MAX_MODELS*(2**AW)-1];
    logic [WEIGHT_W-1:0] wt_mem   [0:(2**MW)-1];
    logic [WAVE_W-1:0]   r_grid_rdata;
    logic [FLUX_W-1:0]   r_flux_rdata;
    logic [WEIGHT_W-1:0] r_wt_rdata;

    // Grid memory.
    always_ff @(posedge i_clk) begin
        if (i_grid_we) begin
            grid_mem[i_grid_waddr] <= i_grid_wdata;
        end
        r_grid_rdata <= grid_mem[i_grid_raddr];
    end

    // Flux memory, model-major.
    always_ff @(posedge i_clk) begin
        if (i_flux_we) begin
            flux_mem[i_flux_waddr] <= i_flux_wdata;
        end
        r_flux_rdata <= flux_mem[i_flux_raddr];
    end

    // Weight memory.
    always_ff @(posedge i_clk) begin
        if (i_wt_we) begin
            wt_mem[i_wt_waddr] <= i_wt_wdata;
        end
        r_wt_rdata <= wt_mem[i_wt_raddr];
    end

    assign o_grid_rdata = r_grid_rdata;
    assign o_flux_rdata = r_flux_rdata;
    assign o_wt_rdata   = r_wt_rdata;
endmodule

### rtl/weighted_spectrum_resampler.sv
// ---------------------------------------------------------------------------
// weighted_spectrum_resampler
// Linear interpolation of many library spectra on one shared grid, summed
// with per-model weights.
// ---------------------------------------------------------------------------
// Load requests (grid point, flux sample, weight) give no result. A query
// outside the grid skips the search and the division. A query is paced by
// the memories, each with one registered read port and read during the
// binary search, by the 16-step serial divider, and by the shared
// multiplier, used twice per model. The block takes no request while a
// query is in progress. Stores hold nothing defined until written.
module weighted_spectrum_resampler
    import wsr_pkg::*;
#(
    parameter int MAX_MODELS      = 64,
    parameter int MAX_GRID_POINTS = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    wsr_req_if.sink                i_req,
    wsr_rsp_if.source              o_rsp,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int AW = (MAX_GRID_POINTS > 2) ? $clog2(MAX_GRID_POINTS) : 1;
    localparam int MW = (MAX_MODELS > 2) ? $clog2(MAX_MODELS) : 1;
    localparam int NW = $clog2(MAX_GRID_POINTS + 1);
    localparam int CW = $clog2(MAX_MODELS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RDN, S_CHK, S_SRCH, S_CMP, S_DIV,
        S_FLO, S_FHI, S_MUL1, S_MUL2, S_ACC, S_OUT
    } t_state;

    t_state                  r_state, n_state;
    logic [MODELS_W-1:0]     r_models;
    logic [POINTS_W-1:0]     r_points;
    logic [WAVE_W-1:0]       r_w, n_w;
    logic [CW-1:0]           r_nm, n_nm;
    logic [CW-1:0]           r_m, n_m;
    logic [AW-1:0]           r_last, n_last;
    logic [AW-1:0]           r_lo, n_lo;
    logic [AW-1:0]           r_hi, n_hi;
    logic [AW-1:0]           r_mid, n_mid;
    logic [WAVE_W-1:0]       r_glo, n_glo;
    logic [WAVE_W-1:0]       r_ghi, n_ghi;
    logic [DIV_STEPS-1:0]    r_t, n_t;
    logic [FLUX_W-1:0]       r_flo, n_flo;
    logic [WEIGHT_W-1:0]     r_wt, n_wt;
    logic [ACC_W-1:0]        r_acc, n_acc;
    logic                    r_o_valid, n_o_valid;
    logic [RESULT_W-1:0]     r_o_flux, n_o_flux;
    logic                    r_o_sat, n_o_sat;

    logic                    req_acc;
    logic [CW-1:0]           nm_c;
    logic [NW-1:0]           n_c;
    logic [AW:0]             mid_sum;
    logic                    div_start;
    logic                    div_done;
    logic [DIV_STEPS-1:0]    div_quot;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic signed [2*MUL_W-1:0] f_wide;
    logic [ACC_W-1:0]        term;
    logic                    sat_hi, sat_lo;
    logic [AW-1:0]           grid_raddr;
    logic [MW+AW-1:0]        flux_raddr;
    logic [WAVE_W-1:0]       grid_rdata;
    logic [FLUX_W-1:0]       flux_rdata;
    logic [WEIGHT_W-1:0]     wt_rdata;
    logic                    grid_we, flux_we, wt_we;
    logic                    pt_ok, mdl_ok;

    assign req_acc     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_models <= MODELS_RESET;
            r_points <= POINTS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODELS: r_models <= i_cfg_data[MODELS_W-1:0];
                CFG_POINTS: r_points <= i_cfg_data;
                default:    r_points <= r_points;
            endcase
        end
    end

    // Register values clamped to the store depths.
    assign nm_c = (32'(r_models) > MAX_MODELS) ? CW'(MAX_MODELS) : CW'(r_models);
    assign n_c  = (32'(r_points) > MAX_GRID_POINTS) ? NW'(MAX_GRID_POINTS)
                                                    : NW'(r_points);

    // Store writes; loads with an index beyond the depth are dropped.
    assign pt_ok   = 32'(i_req.point_index) < MAX_GRID_POINTS;
    assign mdl_ok  = 32'(i_req.model_index) < MAX_MODELS;
    assign grid_we = req_acc && (i_req.func == FUNC_GRID) && pt_ok;
    assign flux_we = req_acc && (i_req.func == FUNC_FLUX) && pt_ok && mdl_ok;
    assign wt_we   = req_acc && (i_req.func == FUNC_WEIGHT) && mdl_ok;

    // Memory read addresses follow the sequencer state.
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    always_comb begin
        case (r_state)
            S_RD0:   grid_raddr = '0;
            S_RDN:   grid_raddr = r_last;
            default: grid_raddr = mid_sum[AW:1];
        endcase
    end
    assign flux_raddr = {r_m[MW-1:0], (r_state == S_FLO) ? r_lo : r_hi};

    wsr_mem #(
        .AW(AW), .MW(MW), .MAX_MODELS(MAX_MODELS)
    ) u_mem (
        .i_clk        (i_clk),
        .i_grid_we    (grid_we),
        .i_grid_waddr (AW'(i_req.point_index)),
        .i_grid_raddr (grid_raddr),
        .i_grid_wdata (i_req.wavelength),
        .o_grid_rdata (grid_rdata),
        .i_flux_we    (flux_we),
        .i_flux_waddr ({MW'(i_req.model_index), AW'(i_req.point_index)}),
        .i_flux_raddr (flux_raddr),
        .i_flux_wdata (i_req.flux_sample),
        .o_flux_rdata (flux_rdata),
        .i_wt_we      (wt_we),
        .i_wt_waddr   (MW'(i_req.model_index)),
        .i_wt_raddr   (r_m[MW-1:0]),
        .i_wt_wdata   (i_req.weight),
        .o_wt_rdata   (wt_rdata)
    );

    wsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (r_w - r_glo),
        .i_denom (r_ghi - r_glo),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Interpolated flux from the first product, then weight times flux.
    assign f_wide = $signed({{(2*MUL_W-FLUX_W){1'b0}}, r_flo}) + (mul_p >>> 16);
    always_comb begin
        if (r_state == S_MUL2) begin
            mul_a = MUL_W'($signed(r_wt));
            mul_b = f_wide[MUL_W-1:0];
        end else begin
            mul_a = $signed({{(MUL_W-DIV_STEPS){1'b0}}, r_t});
            mul_b = $signed({2'b00, flux_rdata}) - $signed({2'b00, r_flo});
        end
    end

    wsr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    assign term   = ACC_W'(mul_p >>> 14);
    assign sat_hi = !r_acc[ACC_W-1] && (r_acc[ACC_W-2:RESULT_W-1] != '0);
    assign sat_lo = r_acc[ACC_W-1] && (r_acc[ACC_W-2:RESULT_W-1] != '1);

    // Sequencer next state.
    always_comb begin
        n_state   = r_state;
        n_w       = r_w;
        n_nm      = r_nm;
        n_m       = r_m;
        n_last    = r_last;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_glo     = r_glo;
        n_ghi     = r_ghi;
        n_t       = r_t;
        n_flo     = r_flo;
        n_wt      = r_wt;
        n_acc     = r_acc;
        n_o_valid = r_o_valid;
        n_o_flux  = r_o_flux;
        n_o_sat   = r_o_sat;
        div_start = 1'b0;
        if (o_rsp.valid && o_rsp.ready) begin
            n_o_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (req_acc && (i_req.func == FUNC_QUERY)) begin
                    n_w    = i_req.wavelength;
                    n_nm   = nm_c;
                    n_m    = '0;
                    n_last = AW'(n_c - 1'b1);
                    n_acc  = '0;
                    n_state = ((nm_c == '0) || (n_c < NW'(2))) ? S_OUT : S_RD0;
                end
            end
            S_RD0: n_state = S_RDN;
            S_RDN: begin
                n_glo   = grid_rdata;
                n_state = S_CHK;
            end
            S_CHK: begin
                n_ghi = grid_rdata;
                n_lo  = '0;
                n_hi  = r_last;
                n_t   = '0;
                if (r_w <= r_glo) begin
                    n_hi    = '0;
                    n_state = S_FLO;
                end else if (r_w >= grid_rdata) begin
                    n_lo    = r_last;
                    n_state = S_FLO;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (({1'b0, r_lo} + 1'b1) < {1'b0, r_hi}) begin
                    n_mid   = mid_sum[AW:1];
                    n_state = S_CMP;
                end else if ((r_ghi <= r_glo) || (r_w < r_glo)) begin
                    n_state = S_FLO;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_CMP: begin
                if (grid_rdata <= r_w) begin
                    n_lo  = r_mid;
                    n_glo = grid_rdata;
                end else begin
                    n_hi  = r_mid;
                    n_ghi = grid_rdata;
                end
                n_state = S_SRCH;
            end
            S_DIV: begin
                if (div_done) begin
                    n_t     = div_quot;
                    n_state = S_FLO;
                end
            end
            S_FLO: n_state = S_FHI;
            S_FHI: begin
                n_flo   = flux_rdata;
                n_wt    = wt_rdata;
                n_state = S_MUL1;
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_ACC;
            S_ACC: begin
                n_acc   = r_acc + term;
                n_m     = r_m + 1'b1;
                n_state = ((r_m + 1'b1) == r_nm) ? S_OUT : S_FLO;
            end
            S_OUT: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid = 1'b1;
                    n_o_sat   = sat_hi || sat_lo;
                    if (sat_hi) begin
                        n_o_flux = {1'b0, {(RESULT_W-1){1'b1}}};
                    end else if (sat_lo) begin
                        n_o_flux = {1'b1, {(RESULT_W-1){1'b0}}};
                    end else begin
                        n_o_flux = r_acc[RESULT_W-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_w      <= n_w;
        r_nm     <= n_nm;
        r_m      <= n_m;
        r_last   <= n_last;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_glo    <= n_glo;
        r_ghi    <= n_ghi;
        r_t      <= n_t;
        r_flo    <= n_flo;
        r_wt     <= n_wt;
        r_acc    <= n_acc;
        r_o_flux <= n_o_flux;
        r_o_sat  <= n_o_sat;
    end

    assign o_rsp.valid            = r_o_valid;
    assign o_rsp.synthesized_flux = r_o_flux;
    assign o_rsp.saturated        = r_o_sat;
endmodule

### rtl/wsr_checker.sv
// ---------------------------------------------------------------------------
// wsr_checker
// Port-level assertions for the weighted spectrum resampler.
// ---------------------------------------------------------------------------
`include "weighted_spectrum_resampler_macros.svh"

module wsr_checker
    import wsr_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic [1:0]          i_req_func,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [RESULT_W-1:0] i_rsp_flux,
    input logic                i_rsp_sat
);
    // A stalled result stays offered and unchanged.
    `WSR_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)
    `WSR_ASSERT_NXT(a_rsp_stable, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, $stable(i_rsp_flux) && $stable(i_rsp_sat))

    // A clipped sum sits at one of the two range limits.
    `WSR_ASSERT_IMP(a_sat_limit, i_clk, i_rst_n, i_rsp_valid && i_rsp_sat, (i_rsp_flux == 32'h7FFF_FFFF) || (i_rsp_flux == 32'h8000_0000))

    // A query blocks further requests while it is worked on.
    `WSR_ASSERT_NXT(a_query_busy, i_clk, i_rst_n, i_req_valid && i_req_ready && (i_req_func == FUNC_QUERY), !i_req_ready)
endmodule

bind weighted_spectrum_resampler wsr_checker u_wsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_func  (i_req.func),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_flux  (o_rsp.synthesized_flux),
    .i_rsp_sat   (o_rsp.saturated)
);
